FILE: hw/rtl/fpd_pkg.sv
// Package for the factorial power divisibility block.
// Widths, defaults and sequencer state type; no dependencies.
package fpd_pkg;
   localparam int NBitsDefault = 60;
   localparam int KBitsDefault = 40;
   localparam int ExpBits      = 63;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRY,       // divide remaining K by candidate
      ST_TRY_CHK,   // candidate past sqrt(K), factor, or next candidate
      ST_STRIP,     // divide K by prime, count multiplicity
      ST_STRIP_CHK,
      ST_LEG_INIT,
      ST_SUM,       // term / p
      ST_SUM_CHK,   // add term, stop when it reaches zero
      ST_CNT_DIV,   // sum / cnt
      ST_CNT_CHK,
      ST_DONE
   } fpd_state_type;
endpackage

FILE: hw/rtl/fpd_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses fpd_pkg; shared by all divisions of the block.
module fpd_divider
   import fpd_pkg::*;
#(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

FILE: hw/rtl/factorial_power_divisibility.sv
// Top level: largest M with K^M dividing N!, by trial division and Legendre sums.
// Uses fpd_pkg and fpd_divider.
//
//   channel | dir | contents
//   req     | in  | tdata: n_value, k_value
//   rsp     | out | tdata: max_exponent; tuser: no_prime_factor
//
// Every division goes through the single shared divider. A request costs one
// division per trial candidate up to sqrt of the remaining K, one per stripped
// factor plus one, and per prime floor(log_p N) + 2 more, plus the sequencing
// states; not ready meanwhile. A response waits in its own output register; the
// sequencer only stalls in DONE while that register is full and not taken.
// Reset is synchronous, clears control.
module factorial_power_divisibility
   import fpd_pkg::*;
#(
   parameter int N_BITS = NBitsDefault,
   parameter int K_BITS = KBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((N_BITS+K_BITS+7)/8)*8-1:0] req_tdata, // n_value, k_value
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [ExpBits:0] rsp_tdata,                    // max_exponent, pad
   output logic rsp_tuser                                 // no_prime_factor
);
   localparam int DW = 64;
   localparam int RW = ((N_BITS + K_BITS + 7) / 8) * 8;

   fpd_state_type state_ff, state_in;
   logic [N_BITS-1:0]  n_ff, n_in;
   logic [K_BITS-1:0]  k_ff, k_in, i_ff, i_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [DW-1:0]      term_ff, term_in, sum_ff, sum_in;
   logic [ExpBits-1:0] best_ff, best_in, out_exp_ff, out_exp_in;
   logic               any_ff, any_in, out_npf_ff, out_npf_in, vld_ff, vld_in;
   logic               dstart;
   logic [DW-1:0]      dend, dsor, dquo, drem;
   logic               ddone;
   logic [DW-1:0]      i_ext, k_ext;

   fpd_divider #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dend),
      .divisor(dsor), .done(ddone), .quotient(dquo), .remainder(drem)
   );

   assign i_ext = {{(DW-K_BITS){1'b0}}, i_ff};
   assign k_ext = {{(DW-K_BITS){1'b0}}, k_ff};

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; k_in = k_ff; i_in = i_ff; cnt_in = cnt_ff;
      term_in = term_ff; sum_in = sum_ff; best_in = best_ff; any_in = any_ff;
      out_exp_in = out_exp_ff; out_npf_in = out_npf_ff; vld_in = vld_ff;
      dstart = 1'b0;
      dend = k_ext;
      dsor = i_ext;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in    = req_tdata[N_BITS-1:0];
               k_in    = req_tdata[N_BITS +: K_BITS];
               i_in    = K_BITS'(2);
               best_in = '1;
               any_in  = 1'b0;
               if (req_tdata[N_BITS +: K_BITS] == '0) begin
                  best_in  = '0;
                  any_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_TRY;
               end
            end
         end
         ST_TRY: begin
            dstart = 1'b1;
            state_in = ST_TRY_CHK;
         end
         ST_TRY_CHK: begin
            if (ddone) begin
               if (i_ext > dquo) begin
                  // i*i > K: what is left is a prime or one
                  if (k_ff > K_BITS'(1)) begin
                     i_in = k_ff;
                     cnt_in = 7'd1;
                     state_in = ST_LEG_INIT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else if (drem == '0) begin
                  k_in = dquo[K_BITS-1:0];
                  cnt_in = 7'd1;
                  state_in = ST_STRIP;
               end else begin
                  i_in = i_ff + K_BITS'(1);
                  state_in = ST_TRY;
               end
            end
         end
         ST_STRIP: begin
            dstart = 1'b1;
            state_in = ST_STRIP_CHK;
         end
         ST_STRIP_CHK: begin
            if (ddone) begin
               if (drem == '0) begin
                  k_in = dquo[K_BITS-1:0];
                  cnt_in = cnt_ff + 7'd1;
                  state_in = ST_STRIP;
               end else begin
                  state_in = ST_LEG_INIT;
               end
            end
         end
         ST_LEG_INIT: begin
            term_in  = {{(DW-N_BITS){1'b0}}, n_ff};
            sum_in   = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            dstart = 1'b1;
            dend = term_ff;
            state_in = ST_SUM_CHK;
         end
         ST_SUM_CHK: begin
            // floor(floor(N/p^j)/p) = floor(N/p^(j+1))
            if (ddone) begin
               sum_in  = sum_ff + dquo;
               term_in = dquo;
               if (dquo == '0) begin
                  state_in = ST_CNT_DIV;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_CNT_DIV: begin
            dstart = 1'b1;
            dend = sum_ff;
            dsor = {{(DW-7){1'b0}}, cnt_ff};
            state_in = ST_CNT_CHK;
         end
         ST_CNT_CHK: begin
            if (ddone) begin
               any_in = 1'b1;
               if (dquo < {1'b0, best_ff}) best_in = dquo[ExpBits-1:0];
               if (k_ff == i_ff) begin
                  state_in = ST_DONE;
               end else begin
                  i_in = i_ff + K_BITS'(1);
                  state_in = ST_TRY;
               end
            end
         end
         ST_DONE: begin
            if (!vld_ff || rsp_tready) begin
               out_exp_in = best_ff;
               out_npf_in = !any_ff;
               vld_in     = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      n_ff <= n_in; k_ff <= k_in; i_ff <= i_in; cnt_ff <= cnt_in;
      term_ff <= term_in; sum_ff <= sum_in; best_ff <= best_in; any_ff <= any_in;
      out_exp_ff <= out_exp_in; out_npf_ff <= out_npf_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {1'b0, out_exp_ff};
   assign rsp_tuser  = out_npf_ff;
   logic unused_ok;
   assign unused_ok = ^req_tdata[RW-1:N_BITS+K_BITS-1];
endmodule

FILE: verif/tb.sv
// Testbench for factorial_power_divisibility: streams (N, K) requests and checks
// each response against typed results or a behavioural Legendre-formula predictor.
// Depends on fpd_pkg and the factorial_power_divisibility RTL.
`timescale 1ns / 1ps

module tb;
   import fpd_pkg::*;

   localparam int NB = NBitsDefault;
   localparam int KB = KBitsDefault;
   localparam int DW = ((NB + KB + 7) / 8) * 8;
   localparam int IDLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 3000;
   localparam int RANDOM_ITEMS = 80;
   localparam logic [ExpBits-1:0] EXP_ALL_ONES = '1;

   typedef struct {
      logic [ExpBits-1:0] exponent;
      logic               unbounded;
   } fpd_rsp_type;

   typedef struct {
      logic [NB-1:0]      n;
      logic [KB-1:0]      k;
      bit                 typed;
      logic [ExpBits-1:0] exponent;
      logic               unbounded;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;    // n_value, k_value
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ExpBits:0] rsp_tdata;      // max_exponent, pad
   logic rsp_tuser;                  // no_prime_factor

   fpd_rsp_type pending_exponents[$];
   int n_errors = 0;
   int n_requests = 0;
   int n_responses = 0;
   int n_typed = 0;
   bit stim_done = 1'b0;

   factorial_power_divisibility i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned legendre_sum(longint unsigned p, longint unsigned n);
      longint unsigned total;
      longint unsigned pw;
      total = 0;
      pw = p;
      if (p < 2 || pw > n) return 0;
      forever begin
         total += n / pw;
         if (pw > n / p) break;
         pw *= p;
      end
      return total;
   endfunction

   function automatic fpd_rsp_type predict_exponent(logic [NB-1:0] n_in, logic [KB-1:0] k_in);
      fpd_rsp_type r;
      longint unsigned n;
      longint unsigned k;
      longint unsigned best;
      longint unsigned i;
      longint unsigned mult;
      longint unsigned q;
      bit any;
      n = n_in;
      k = k_in;
      best = EXP_ALL_ONES;
      any = 1'b0;
      if (k == 0) begin
         r.exponent = '0;
         r.unbounded = 1'b0;
         return r;
      end
      for (i = 2; i * i <= k; i++) begin
         if (k % i == 0) begin
            mult = 0;
            while (k % i == 0) begin
               mult++;
               k /= i;
            end
            q = legendre_sum(i, n) / mult;
            if (q < best) best = q;
            any = 1'b1;
         end
      end
      if (k > 1) begin
         q = legendre_sum(k, n);
         if (q < best) best = q;
         any = 1'b1;
      end
      r.exponent = best[ExpBits-1:0];
      r.unbounded = !any;
      return r;
   endfunction

   // K with only small prime factors: large but quick to factor
   function automatic logic [KB-1:0] smooth_k();
      longint unsigned k;
      longint unsigned p;
      int primes[6] = '{2, 3, 5, 7, 11, 13};
      k = 1;
      repeat ($urandom_range(1, 40)) begin
         p = primes[$urandom_range(0, 5)];
         if (k * p < (64'd1 << KB)) k *= p;
      end
      return k[KB-1:0];
   endfunction

   function automatic logic [NB-1:0] random_n();
      case ($urandom_range(0, 2))
         0: return NB'($urandom_range(0, 100));
         1: return NB'($urandom_range(0, 1000000));
         default: return NB'({$urandom, $urandom});
      endcase
   endfunction

   task automatic send_request(logic [NB-1:0] n, logic [KB-1:0] k, bit typed,
                               fpd_rsp_type typed_rsp);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(DW - NB - KB){1'b0}}, k, n};
      do @(posedge clock); while (!req_tready);
      pending_exponents = {pending_exponents,
                           (typed ? typed_rsp : predict_exponent(n, k))};
      n_requests++;
   endtask

   stim_row_type directed[] = '{
      '{60'd0, 40'd1, 1'b1, EXP_ALL_ONES, 1'b1},
      '{60'hFFF_FFFF_FFFF_FFFF, 40'd1, 1'b1, EXP_ALL_ONES, 1'b1},
      '{60'd12345, 40'd0, 1'b1, 63'd0, 1'b0},
      '{60'hFFF_FFFF_FFFF_FFFF, 40'd0, 1'b1, 63'd0, 1'b0},
      '{60'd0, 40'd2, 1'b1, 63'd0, 1'b0},
      '{60'd1, 40'd2, 1'b1, 63'd0, 1'b0},
      '{60'd6, 40'd7, 1'b1, 63'd0, 1'b0},
      '{60'd10, 40'd2, 1'b1, 63'd8, 1'b0},
      '{60'd10, 40'd10, 1'b1, 63'd2, 1'b0},
      '{60'd1000, 40'd97, 1'b0, '0, 1'b0},
      '{60'd100, 40'd12, 1'b0, '0, 1'b0},
      '{60'hFFF_FFFF_FFFF_FFFF, 40'd2, 1'b0, '0, 1'b0},
      '{60'hFFF_FFFF_FFFF_FFFF, 40'd3, 1'b0, '0, 1'b0},
      '{60'hFFF_FFFF_FFFF_FFFF, 40'h80_0000_0000, 1'b0, '0, 1'b0},
      '{60'hFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0, '0, 1'b0},
      '{60'd1000000, 40'hFF_FFFF_FFFF, 1'b0, '0, 1'b0},
      '{60'h800_0000_0000_0000, 40'd4093, 1'b0, '0, 1'b0},
      '{60'd4092, 40'd4093, 1'b1, 63'd0, 1'b0},
      '{60'd4093, 40'd4093, 1'b1, 63'd1, 1'b0}
   };

   initial begin
      fpd_rsp_type r;
      logic [KB-1:0] k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[j]) begin
         r.exponent = directed[j].exponent;
         r.unbounded = directed[j].unbounded;
         if (directed[j].typed) n_typed++;
         send_request(directed[j].n, directed[j].k, directed[j].typed, r);
      end
      repeat (RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: k = KB'($urandom_range(0, 1));
            1, 2: k = smooth_k();
            default: k = KB'($urandom_range(2, 4095));
         endcase
         send_request(random_n(), k, 1'b0, r);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // response side: random stalls, one long hold-off while requests are still offered, and a stall-free stretch
   initial begin
      fpd_rsp_type exp_rsp;
      int stall;
      bit held;
      stall = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            n_responses++;
            if (pending_exponents.size() == 0) begin
               $display("%0t: response with no request outstanding: %h/%b", $time,
                        rsp_tdata[ExpBits-1:0], rsp_tuser);
               n_errors++;
            end else begin
               exp_rsp = pending_exponents.pop_front();
               if (rsp_tdata[ExpBits-1:0] !== exp_rsp.exponent) begin
                  $display("%0t: max_exponent expected %0d actual %0d", $time,
                           exp_rsp.exponent, rsp_tdata[ExpBits-1:0]);
                  n_errors++;
               end
               if (rsp_tuser !== exp_rsp.unbounded) begin
                  $display("%0t: no_prime_factor expected %b actual %b", $time,
                           exp_rsp.unbounded, rsp_tuser);
                  n_errors++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!held && n_responses == 5) begin
            held = 1'b1;
            stall = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (n_responses > 60 && n_responses < 75) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                : $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d responses outstanding", $time,
                     pending_exponents.size());
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      wait (stim_done);
      while (pending_exponents.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d requests (%0d with typed results), %0d responses checked, %0d errors",
               n_requests, n_typed, n_responses, n_errors);
      if (n_errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
